[rtl/core/rts_pkg.sv]
// Shared types, constants and the arctangent table for the right-triangle solver.
// No dependencies.
package rts_pkg;

  localparam int FRAC_BITS    = 8;
  localparam int SIDE_W       = 16 + FRAC_BITS;
  localparam int SQ_W         = 2 * SIDE_W;
  localparam int RAD_W        = SQ_W + 2;
  localparam int ROOT_W       = SIDE_W + 1;
  localparam int REM_W        = ROOT_W + 2;
  localparam int SQ_STEPS     = RAD_W / 2;
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_PRE   = 16;
  localparam int CX_W         = SIDE_W + CORDIC_PRE + 3;
  localparam int CZ_W         = 29;
  localparam int ANG_W        = 23;
  localparam int LEN_W        = 25;

  localparam logic [ANG_W-1:0] ANG_90 = 23'd5898240;

  typedef enum logic [1:0] {
    OP_LEG   = 2'd0,
    OP_HYP   = 2'd1,
    OP_ANGLE = 2'd2
  } rts_op_e;

  typedef struct packed {
    logic                    bad;
    logic                    len_op;
    logic                    ang_op;
    logic                    ang_x0;
    logic                    ang_y0;
    logic [RAD_W-1:0]        sq_v;
    logic [REM_W-1:0]        sq_rem;
    logic [ROOT_W-1:0]       sq_root;
    logic signed [CX_W-1:0]  cx;
    logic signed [CX_W-1:0]  cy;
    logic signed [CZ_W-1:0]  cz;
  } rts_word_t;

  function automatic logic signed [CZ_W-1:0] atan_val(input logic [4:0] idx);
    logic signed [CZ_W-1:0] r;
    case (idx)
      5'd0:  r = 29'sd47185920;
      5'd1:  r = 29'sd27855475;
      5'd2:  r = 29'sd14718068;
      5'd3:  r = 29'sd7471121;
      5'd4:  r = 29'sd3750058;
      5'd5:  r = 29'sd1876857;
      5'd6:  r = 29'sd938658;
      5'd7:  r = 29'sd469357;
      5'd8:  r = 29'sd234682;
      5'd9:  r = 29'sd117342;
      5'd10: r = 29'sd58671;
      5'd11: r = 29'sd29335;
      5'd12: r = 29'sd14668;
      5'd13: r = 29'sd7334;
      5'd14: r = 29'sd3667;
      5'd15: r = 29'sd1833;
      5'd16: r = 29'sd917;
      5'd17: r = 29'sd458;
      5'd18: r = 29'sd229;
      5'd19: r = 29'sd115;
      5'd20: r = 29'sd57;
      5'd21: r = 29'sd29;
      5'd22: r = 29'sd14;
      5'd23: r = 29'sd7;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/rts_front.sv]
// Input stage: registers the squares of both sides and decodes the op.
// Depends on rts_pkg.
module rts_front import rts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [1:0]        op_i,
  input  logic [SIDE_W-1:0] side_x_i,
  input  logic [SIDE_W-1:0] side_y_i,
  output logic              valid_o,
  output rts_word_t         word_o
);

  logic              valid_q;
  logic [1:0]        op_q;
  logic [SIDE_W-1:0] x_q, y_q;
  logic [SQ_W-1:0]   xsq_q, ysq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q  <= op_i;
      x_q   <= side_x_i;
      y_q   <= side_y_i;
      xsq_q <= side_x_i * side_x_i;
      ysq_q <= side_y_i * side_y_i;
    end
  end

  always_comb begin
    word_o         = '0;
    word_o.cx      = $signed({3'b000, x_q, 16'h0000});
    word_o.cy      = $signed({3'b000, y_q, 16'h0000});
    word_o.ang_x0  = (x_q == '0);
    word_o.ang_y0  = (y_q == '0);
    case (op_q)
      OP_LEG: begin
        if (x_q < y_q) begin
          word_o.bad = 1'b1;
        end else begin
          word_o.len_op = 1'b1;
          word_o.sq_v   = {2'b00, xsq_q - ysq_q};
        end
      end
      OP_HYP: begin
        word_o.len_op = 1'b1;
        word_o.sq_v   = {1'b0, {1'b0, xsq_q} + {1'b0, ysq_q}};
      end
      OP_ANGLE: begin
        if (x_q == '0 && y_q == '0) begin
          word_o.bad = 1'b1;
        end else begin
          word_o.ang_op = 1'b1;
        end
      end
      default: word_o.bad = 1'b1;
    endcase
  end

  assign valid_o = valid_q;

endmodule

[rtl/core/rts_iter.sv]
// One pipeline step: one root bit of the square root and, while step_i < CORDIC_STEPS, one CORDIC rotation.
// Depends on rts_pkg.
module rts_iter import rts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  logic [4:0] step_i,
  input  rts_word_t word_i,
  output logic      valid_o,
  output rts_word_t word_o
);

  logic      valid_q;
  rts_word_t word_q, word_d;
  logic [REM_W+1:0] acc, trial;
  logic signed [CX_W-1:0] dx, dy;

  always_comb begin
    word_d = word_i;
    acc    = {word_i.sq_rem, word_i.sq_v[RAD_W-1 -: 2]};
    trial  = {2'b00, word_i.sq_root, 2'b01};
    word_d.sq_v = {word_i.sq_v[RAD_W-3:0], 2'b00};
    if (acc >= trial) begin
      word_d.sq_rem  = REM_W'(acc - trial);
      word_d.sq_root = {word_i.sq_root[ROOT_W-2:0], 1'b1};
    end else begin
      word_d.sq_rem  = acc[REM_W-1:0];
      word_d.sq_root = {word_i.sq_root[ROOT_W-2:0], 1'b0};
    end
    dx = word_i.cy >>> step_i;
    dy = word_i.cx >>> step_i;
    if (step_i < 5'(CORDIC_STEPS)) begin
      if (!word_i.cy[CX_W-1]) begin
        word_d.cx = word_i.cx + dx;
        word_d.cy = word_i.cy - dy;
        word_d.cz = word_i.cz + atan_val(step_i);
      end else begin
        word_d.cx = word_i.cx - dx;
        word_d.cy = word_i.cy + dy;
        word_d.cz = word_i.cz - atan_val(step_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

[rtl/core/rts_back.sv]
// Output stage: angle rounding and clamping, special cases, result register.
// Depends on rts_pkg.
module rts_back import rts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  rts_word_t        word_i,
  output logic             valid_o,
  output logic [LEN_W-1:0] length_out_o,
  output logic [ANG_W-1:0] angle_first_o,
  output logic [ANG_W-1:0] angle_second_o,
  output logic             invalid_o
);

  logic             valid_q, bad_q;
  logic [LEN_W-1:0] len_q, len_d;
  logic [ANG_W-1:0] a1_q, a2_q, a1_d, a2_d;
  logic signed [CZ_W-1:0] rz;

  always_comb begin
    rz    = (word_i.cz + 29'sd8) >>> 4;
    len_d = word_i.len_op ? LEN_W'(word_i.sq_root) : '0;
    a1_d  = '0;
    a2_d  = '0;
    if (word_i.ang_op) begin
      if (word_i.ang_x0) begin
        a1_d = ANG_90;
      end else if (word_i.ang_y0) begin
        a1_d = '0;
      end else if (rz < 0) begin
        a1_d = '0;
      end else if (rz > $signed({6'd0, ANG_90})) begin
        a1_d = ANG_90;
      end else begin
        a1_d = rz[ANG_W-1:0];
      end
      a2_d = ANG_90 - a1_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q <= len_d;
      a1_q  <= a1_d;
      a2_q  <= a2_d;
      bad_q <= word_i.bad;
    end
  end

  assign valid_o        = valid_q;
  assign length_out_o   = len_q;
  assign angle_first_o  = a1_q;
  assign angle_second_o = a2_q;
  assign invalid_o      = bad_q;

endmodule

[rtl/core/right_triangle_solver_top.sv]
// Right-triangle solver top: square stage, 25 root/CORDIC steps, output stage.
// One word per cycle, unless out_ready_i low stalls the output stage and the stages behind it.
// Each stage loads whenever it is empty or the stage after it moves, so bubbles close up.
// Reset (rst_ni low, async) clears all stage valid bits; no other state.
// Depends on rts_pkg, rts_front, rts_iter, rts_back.
module right_triangle_solver_top import rts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       op_i,
  input  logic [SIDE_W-1:0] side_x_i,
  input  logic [SIDE_W-1:0] side_y_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [LEN_W-1:0] length_out_o,
  output logic [ANG_W-1:0] angle_first_o,
  output logic [ANG_W-1:0] angle_second_o,
  output logic             invalid_o
);

  rts_word_t w   [0:SQ_STEPS];
  logic      vld [0:SQ_STEPS+1];
  logic      rdy [0:SQ_STEPS+1];

  rts_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (rdy[0]),
    .valid_i  (in_valid_i),
    .op_i     (op_i),
    .side_x_i (side_x_i),
    .side_y_i (side_y_i),
    .valid_o  (vld[0]),
    .word_o   (w[0])
  );

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_iter
    rts_iter u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (rdy[k+1]),
      .valid_i (vld[k]),
      .step_i  (5'(k)),
      .word_i  (w[k]),
      .valid_o (vld[k+1]),
      .word_o  (w[k+1])
    );
  end

  rts_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (rdy[SQ_STEPS+1]),
    .valid_i        (vld[SQ_STEPS]),
    .word_i         (w[SQ_STEPS]),
    .valid_o        (vld[SQ_STEPS+1]),
    .length_out_o   (length_out_o),
    .angle_first_o  (angle_first_o),
    .angle_second_o (angle_second_o),
    .invalid_o      (invalid_o)
  );

  assign rdy[SQ_STEPS+1] = !vld[SQ_STEPS+1] || out_ready_i;
  for (genvar k = 0; k <= SQ_STEPS; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld[SQ_STEPS+1];

`ifndef SYNTH
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && invalid_o |->
      length_out_o == '0 && angle_first_o == '0 && angle_second_o == '0)
    else $error("invalid word with nonzero fields");

  a_ang_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !invalid_o && (angle_first_o != '0 || angle_second_o != '0) |->
      ({1'b0, angle_first_o} + {1'b0, angle_second_o}) == {1'b0, ANG_90})
    else $error("angles do not sum to 90");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("pipeline stalled while output drains");
`endif

endmodule

[dv/tb_right_triangle_solver_top.sv]
// Self-checking testbench for right_triangle_solver_top: directed and random words,
// predicted in-line (integer square root, CORDIC arctangent) and checked in order.
// Depends on rts_pkg and the RTL of right_triangle_solver_top.
`timescale 1ns / 1ps

module tb_right_triangle_solver_top;
  import rts_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         N_RANDOM  = 1400;
  localparam int         LIMIT     = 600000;
  localparam logic [SIDE_W-1:0] SIDE_MAX = '1;

  typedef struct packed {
    logic [1:0]        op;
    logic [SIDE_W-1:0] x;
    logic [SIDE_W-1:0] y;
  } tri_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [ANG_W-1:0] a1;
    logic [ANG_W-1:0] a2;
    logic             bad;
  } tri_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] op_i = '0;
  logic [SIDE_W-1:0] side_x_i = '0;
  logic [SIDE_W-1:0] side_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [LEN_W-1:0] length_out_o;
  logic [ANG_W-1:0] angle_first_o;
  logic [ANG_W-1:0] angle_second_o;
  logic invalid_o;

  tri_word_t pending_q[$];
  tri_res_t  solved_q[$];
  tri_word_t cur;
  int  sent_cnt = 0;
  int  fail_cnt = 0;
  int  cycle_cnt = 0;
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;
  bit  fill_done = 1'b0;

  right_triangle_solver_top i_dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [ANG_W-1:0] atan_deg(input longint x, input longint y);
    longint cx, cy, z, dx, dy, r;
    cx = x <<< CORDIC_PRE;
    cy = y <<< CORDIC_PRE;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += longint'(atan_val(i[4:0]));
      end else begin
        cx -= dx; cy += dy; z -= longint'(atan_val(i[4:0]));
      end
    end
    r = (z + 8) >>> 4;
    if (r < 0) r = 0;
    if (r > longint'(ANG_90)) r = longint'(ANG_90);
    return r[ANG_W-1:0];
  endfunction

  function automatic tri_res_t solve_triangle(input tri_word_t w);
    tri_res_t r;
    longint unsigned x, y;
    r = '0;
    x = w.x;
    y = w.y;
    case (w.op)
      OP_LEG: begin
        if (x < y) r.bad = 1'b1;
        else r.len = LEN_W'(int_sqrt(x * x - y * y));
      end
      OP_HYP: r.len = LEN_W'(int_sqrt(x * x + y * y));
      OP_ANGLE: begin
        if (x == 0 && y == 0) r.bad = 1'b1;
        else begin
          if (x == 0) r.a1 = ANG_90;
          else if (y == 0) r.a1 = '0;
          else r.a1 = atan_deg(longint'(x), longint'(y));
          r.a2 = ANG_90 - r.a1;
        end
      end
      default: r.bad = 1'b1;
    endcase
    return r;
  endfunction

  function automatic tri_word_t make_word(input logic [1:0] op, input logic [SIDE_W-1:0] x,
                                          input logic [SIDE_W-1:0] y);
    tri_word_t w;
    w.op = op; w.x = x; w.y = y;
    return w;
  endfunction

  function automatic logic [SIDE_W-1:0] rand_side();
    case ($urandom_range(3))
      0: return SIDE_W'($urandom_range(255));
      1: return SIDE_W'($urandom_range(65535));
      default: return SIDE_W'($urandom);
    endcase
  endfunction

  function automatic int idle_pct(input int phase, input bit rx);
    case (phase)
      1: return rx ? 0 : 76;
      2: return rx ? 76 : 0;
      3: return 13;
      default: return 0;
    endcase
  endfunction

  // stimulus
  initial begin
    tri_word_t w;
    logic [SIDE_W-1:0] t;
    pending_q.push_back(make_word(OP_LEG, SIDE_MAX, '0));
    pending_q.push_back(make_word(OP_LEG, SIDE_MAX, SIDE_MAX));
    pending_q.push_back(make_word(OP_LEG, '0, '0));
    pending_q.push_back(make_word(OP_LEG, 24'd100, 24'd101));
    pending_q.push_back(make_word(OP_LEG, 24'd1280, 24'd768));
    pending_q.push_back(make_word(OP_LEG, SIDE_MAX, 24'd1));
    pending_q.push_back(make_word(OP_HYP, '0, '0));
    pending_q.push_back(make_word(OP_HYP, SIDE_MAX, SIDE_MAX));
    pending_q.push_back(make_word(OP_HYP, 24'd768, 24'd1024));
    pending_q.push_back(make_word(OP_HYP, SIDE_MAX, '0));
    pending_q.push_back(make_word(OP_ANGLE, '0, '0));
    pending_q.push_back(make_word(OP_ANGLE, '0, 24'd5));
    pending_q.push_back(make_word(OP_ANGLE, 24'd7, '0));
    pending_q.push_back(make_word(OP_ANGLE, SIDE_MAX, SIDE_MAX));
    pending_q.push_back(make_word(OP_ANGLE, SIDE_MAX, 24'd1));
    pending_q.push_back(make_word(OP_ANGLE, 24'd1, SIDE_MAX));
    pending_q.push_back(make_word(OP_ANGLE, 24'd256, 24'd443));
    pending_q.push_back(make_word(OP_UNUSED, SIDE_MAX, 24'd3));
    pending_q.push_back(make_word(OP_UNUSED, '0, '0));
    for (int n = 0; n < N_RANDOM; n++) begin
      w.x = rand_side();
      w.y = rand_side();
      case ($urandom_range(19))
        0: w.op = OP_UNUSED;
        1, 2, 3, 4, 5, 6: w.op = OP_LEG;
        7, 8, 9, 10, 11, 12: w.op = OP_HYP;
        default: w.op = OP_ANGLE;
      endcase
      // mostly legal legs; equal sides now and then
      if (w.op == OP_LEG && w.x < w.y && $urandom_range(4) != 0) begin
        t = w.x; w.x = w.y; w.y = t;
      end
      if ($urandom_range(49) == 0) w.y = w.x;
      pending_q.push_back(w);
    end
    fill_done = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        solved_q.push_back(solve_triangle(make_word(op_i, side_x_i, side_y_i)));
        sent_cnt <= sent_cnt + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() != 0 &&
            $urandom_range(99) >= idle_pct((sent_cnt / 100) % 4, 1'b0)) begin
          cur = pending_q.pop_front();
          in_valid_i <= 1'b1;
          op_i <= cur.op;
          side_x_i <= cur.x;
          side_y_i <= cur.y;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the pipe fills and backs up
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && sent_cnt >= 300) begin
      hold_cnt <= 200;
      hold_done <= 1'b1;
    end
  end

  // monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    tri_res_t got, want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{len: length_out_o, a1: angle_first_o, a2: angle_second_o, bad: invalid_o};
        if (solved_q.size() == 0) begin
          fail_cnt <= fail_cnt + 1;
          $display("%0t: unexpected word len=%0d a1=%0d a2=%0d bad=%0b", $time,
                   got.len, got.a1, got.a2, got.bad);
        end else begin
          want = solved_q.pop_front();
          if (got.len !== want.len || got.a1 !== want.a1 || got.a2 !== want.a2 ||
              got.bad !== want.bad) begin
            fail_cnt <= fail_cnt + 1;
            $display("%0t: mismatch exp len=%0d a1=%0d a2=%0d bad=%0b", $time,
                     want.len, want.a1, want.a2, want.bad);
            $display("%0t:          got len=%0d a1=%0d a2=%0d bad=%0b", $time,
                     got.len, got.a1, got.a2, got.bad);
          end
        end
      end
      out_ready_i <= (hold_cnt == 0) &&
                     ($urandom_range(99) >= idle_pct((sent_cnt / 100) % 4, 1'b1));
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("** right_triangle_solver_top: FAILED **");
      $finish;
    end
  end

  initial begin
    wait (fill_done && rst_ni);
    wait (pending_q.size() == 0 && !in_valid_i && solved_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0 && solved_q.size() == 0) begin
      $display("** right_triangle_solver_top: PASSED **");
    end else begin
      $display("** right_triangle_solver_top: FAILED **");
    end
    $finish;
  end

endmodule
